FILE: rtl/tkvr_pkg.sv
package tkvr_pkg;

	localparam int LIST_DEPTH_DEF = 100;

	localparam logic [15:0] CFG_RESET = 16'd256;
	localparam logic [15:0] RATIO_MAX = 16'hFFFF;
	localparam logic [19:0] CAP_MAX   = 20'hFFFFF;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [6:0]  rank;
		logic [7:0]  period;
		logic [23:0] link;
		logic        dir;
		logic [23:0] volume;
		logic [19:0] capacity;
		logic [3:0]  lanes;
		logic        use_found;
		logic [3:0]  use_lanes;
	} tkvr_in_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] ratio;
		logic [7:0]  out_period;
		logic [23:0] out_link;
		logic        out_dir;
		logic [19:0] out_volume;
		logic [19:0] out_capacity;
	} tkvr_out_t;

	// one list slot
	typedef struct packed {
		logic [15:0] ratio;
		logic [7:0]  period;
		logic [23:0] link;
		logic        dir;
		logic [19:0] volume;
		logic [19:0] capacity;
	} tkvr_entry_t;

	typedef struct packed {
		logic fin;
		logic ins;
	} tkvr_stat_t;

endpackage

FILE: rtl/top_k_vc_ratio_tracker_unit.sv
// Top-K volume-to-capacity tracker. Raise start with a command beat while busy is low.
// A record beat (mode 0) keeps busy high while the four-bit-a-cycle lane divider runs,
// when a lane-use period applies, and the sixteen-step ratio divider, unless the ratio
// saturates; an item that is skipped (zero volume or zero scaled capacity) runs neither
// and is not stored. Otherwise the entry lands in the list of cells in the insert state.
// A read beat (mode 1) raises busy, and its result shows on result with done high for
// exactly one cycle, in the cycle after busy is high; the receiver cannot stall, so
// capture it then. Record beats produce no result. Write capacity_factor through
// cfg_we/cfg_data only while idle.
module top_k_vc_ratio_tracker_unit #(
	parameter int LIST_DEPTH = tkvr_pkg::LIST_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tkvr_pkg::tkvr_in_t  cmd,
	output logic                done,
	output tkvr_pkg::tkvr_out_t result,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);
	import tkvr_pkg::*;

	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_READ = 3'b010,
		T_CALC = 3'b100
	} tstate_t;

	tstate_t     state_q;
	logic [15:0] factor_q;
	logic [6:0]  rank_q;
	logic        done_q;
	tkvr_out_t   res_q;

	logic        accept;
	logic        go;
	tkvr_stat_t  cst;
	tkvr_entry_t new_e;
	tkvr_entry_t ent [LIST_DEPTH];
	logic        gt  [LIST_DEPTH];
	logic [8:0]  rank_ext;
	logic [IW-1:0] idx;
	logic        in_range;
	tkvr_entry_t sel_e;

	assign busy   = (state_q != T_IDLE);
	assign accept = start && !busy;
	assign go     = accept && (cmd.mode == MODE_RECORD);
	assign done   = done_q;
	assign result = res_q;

	tkvr_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (cmd),
		.factor (factor_q),
		.stat   (cst),
		.ent    (new_e)
	);

	for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
		if (j == 0) begin : g_head
			// head cell: nothing above it to shift in
			tkvr_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ins     (cst.ins),
				.new_e   (new_e),
				.prev_e  ('0),
				.prev_gt (1'b0),
				.e       (ent[j]),
				.gt      (gt[j])
			);
		end else begin : g_body
			tkvr_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ins     (cst.ins),
				.new_e   (new_e),
				.prev_e  (ent[j-1]),
				.prev_gt (gt[j-1]),
				.e       (ent[j]),
				.gt      (gt[j])
			);
		end
	end

	assign rank_ext = {2'b0, rank_q};
	assign idx      = rank_ext[IW-1:0];
	assign in_range = rank_ext < 9'(LIST_DEPTH);
	assign sel_e    = ent[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			factor_q <= CFG_RESET;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) factor_q <= cfg_data;
			done_q <= (state_q == T_READ);
			case (state_q)
				T_IDLE: begin
					if (accept) state_q <= (cmd.mode == MODE_READ) ? T_READ : T_CALC;
				end
				T_READ: begin
					state_q <= T_IDLE;
				end
				T_CALC: begin
					if (cst.fin) state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rank_q <= cmd.rank;
		if (state_q == T_READ) begin
			if (in_range) begin
				res_q.valid_res    <= (sel_e.ratio != 16'd0);
				res_q.ratio        <= sel_e.ratio;
				res_q.out_period   <= sel_e.period;
				res_q.out_link     <= sel_e.link;
				res_q.out_dir      <= sel_e.dir;
				res_q.out_volume   <= sel_e.volume;
				res_q.out_capacity <= sel_e.capacity;
			end else begin
				res_q <= '0;
			end
		end
	end

	ap_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.mode == MODE_READ) |-> ##2 done)
		else $error("read beat did not produce a result");

	ap_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == T_READ))
		else $error("result strobe without a read");

	ap_ins_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cst.ins |-> (state_q == T_CALC))
		else $error("list insert outside a record");

	if (LIST_DEPTH > 1) begin : g_sorted
		ap_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			ent[0].ratio >= ent[1].ratio)
			else $error("list head out of order");
	end

endmodule

FILE: rtl/tkvr_cell.sv
module tkvr_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ins,
	input  tkvr_pkg::tkvr_entry_t new_e,
	input  tkvr_pkg::tkvr_entry_t prev_e,
	input  logic                  prev_gt,
	output tkvr_pkg::tkvr_entry_t e,
	output logic                  gt
);
	import tkvr_pkg::*;

	tkvr_entry_t e_q;

	// the list is sorted, so gt is set from the insertion slot downward
	assign gt = new_e.ratio > e_q.ratio;
	assign e  = e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else if (ins && gt) begin
			// below the slot: take the neighbor's entry; at the slot: take the new one
			e_q <= prev_gt ? prev_e : new_e;
		end
	end

endmodule

FILE: rtl/tkvr_calc.sv
module tkvr_calc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  tkvr_pkg::tkvr_in_t    req,
	input  logic [15:0]           factor,
	output tkvr_pkg::tkvr_stat_t  stat,
	output tkvr_pkg::tkvr_entry_t ent
);
	import tkvr_pkg::*;

	localparam logic [3:0] LDIV_LAST = 4'd7;
	localparam logic [3:0] RDIV_LAST = 4'd15;

	typedef enum logic [6:0] {
		C_IDLE = 7'b0000001,
		C_MUL  = 7'b0000010,
		C_CHK  = 7'b0000100,
		C_LDIV = 7'b0001000,
		C_RSET = 7'b0010000,
		C_RDIV = 7'b0100000,
		C_INS  = 7'b1000000
	} cstate_t;

	cstate_t     state_q;
	logic [3:0]  cnt_q;
	tkvr_in_t    req_q;
	logic [27:0] cap_q;
	logic [3:0]  le_q;
	logic [31:0] tod_q;
	logic [31:0] ldiv_q;
	logic [3:0]  lrem_q;
	logic [36:0] rem_q;
	logic [51:0] dsh_q;
	logic [15:0] quo_q;
	logic [15:0] ratio_q;

	logic [35:0] prod_w;
	logic [3:0]  lanes_w;
	logic [31:0] lprod_w;
	logic        skip_w;
	logic [31:0] ld_w;
	logic [3:0]  lr_w;
	logic [36:0] num_w;
	logic [36:0] den_w;
	logic        ovf_w;
	logic        rge_w;
	logic [24:0] volr_w;

	assign prod_w  = 36'(req_q.capacity) * 36'(factor) + 36'd128;
	assign lanes_w = (req_q.lanes == 4'd0) ? 4'd1 : req_q.lanes;
	assign lprod_w = 32'(cap_q) * 32'(req_q.use_lanes) + 32'(lanes_w >> 1);
	assign skip_w  = (req_q.volume == 24'd0) || (cap_q == 28'd0);

	// lane division: four quotient bits a cycle, remainder stays below the lane count
	always_comb begin
		logic [4:0] t;
		logic       ge;
		ld_w = ldiv_q;
		lr_w = lrem_q;
		for (int i = 0; i < 4; i++) begin
			t    = {lr_w, ld_w[31]};
			ge   = t >= {1'b0, le_q};
			lr_w = ge ? 4'(t - {1'b0, le_q}) : t[3:0];
			ld_w = {ld_w[30:0], ge};
		end
	end

	// round(vol*100 / (16*tod)) = (200*vol + 16*tod) / (32*tod)
	assign num_w = 37'(req_q.volume) * 37'd200 + 37'({tod_q, 4'b0});
	assign den_w = {tod_q, 5'b0};
	// also catches a zero divisor
	assign ovf_w = {16'b0, num_w} >= {den_w, 16'b0};
	assign rge_w = {15'b0, rem_q} >= dsh_q;

	assign volr_w = 25'(req_q.volume) + 25'd8;

	assign stat.ins = (state_q == C_INS);
	assign stat.fin = (state_q == C_INS) || ((state_q == C_CHK) && skip_w);

	assign ent.ratio    = ratio_q;
	assign ent.period   = req_q.period;
	assign ent.link     = req_q.link;
	assign ent.dir      = req_q.dir;
	assign ent.volume   = volr_w[24] ? CAP_MAX : volr_w[23:4];
	assign ent.capacity = (tod_q > 32'(CAP_MAX)) ? CAP_MAX : tod_q[19:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (go) state_q <= C_MUL;
				end
				C_MUL: begin
					state_q <= C_CHK;
				end
				C_CHK: begin
					cnt_q <= '0;
					if (skip_w) state_q <= C_IDLE;
					else if (req_q.use_found) state_q <= C_LDIV;
					else state_q <= C_RSET;
				end
				C_LDIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LDIV_LAST) state_q <= C_RSET;
				end
				C_RSET: begin
					cnt_q <= '0;
					state_q <= ovf_w ? C_INS : C_RDIV;
				end
				C_RDIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == RDIV_LAST) state_q <= C_INS;
				end
				C_INS: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (go) req_q <= req;
			end
			C_MUL: begin
				cap_q <= prod_w[35:8];
			end
			C_CHK: begin
				ldiv_q <= lprod_w;
				lrem_q <= '0;
				le_q   <= lanes_w;
				tod_q  <= 32'(cap_q);
			end
			C_LDIV: begin
				ldiv_q <= ld_w;
				lrem_q <= lr_w;
				// a zero quotient falls back to half the capacity
				if (cnt_q == LDIV_LAST) tod_q <= (ld_w == 32'd0) ? 32'(cap_q >> 1) : ld_w;
			end
			C_RSET: begin
				ratio_q <= RATIO_MAX;
				rem_q   <= num_w;
				dsh_q   <= {den_w, 15'b0};
			end
			C_RDIV: begin
				if (rge_w) rem_q <= rem_q - dsh_q[36:0];
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[14:0], rge_w};
				if (cnt_q == RDIV_LAST) ratio_q <= {quo_q[14:0], rge_w};
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tkvr_pkg::*;

	localparam int DEPTH      = LIST_DEPTH_DEF;
	localparam int CYCLE_CAP  = 500000;
	localparam int SETTLE_CYC = 40;

	typedef struct {
		tkvr_in_t  c;
		bit        typed;
		tkvr_out_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	tkvr_in_t    cmd;
	logic        done;
	tkvr_out_t   result;
	logic        cfg_we;
	logic [15:0] cfg_data;

	// predictor state: sorted ratio list and the capacity scale
	tkvr_entry_t rank_list [DEPTH];
	bit [15:0]   cap_scale;
	tkvr_out_t   pending_reads [$];
	stim_row_t   dir_rows [$];
	tkvr_in_t    last_rec;
	bit          gaps_on;
	int          errors;

	top_k_vc_ratio_tracker_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// compare each read beat against the oldest expectation
	always @(posedge clk) begin
		tkvr_out_t w;
		if (arst_n && done === 1'b1) begin
			if (pending_reads.size() == 0) begin
				flag_mismatch("unexpected result ratio", result.ratio, 0);
			end else begin
				w = pending_reads.pop_front();
				if (result.valid_res !== w.valid_res)
					flag_mismatch("valid_res", result.valid_res, w.valid_res);
				if (result.ratio !== w.ratio)
					flag_mismatch("ratio", result.ratio, w.ratio);
				if (result.out_period !== w.out_period)
					flag_mismatch("out_period", result.out_period, w.out_period);
				if (result.out_link !== w.out_link)
					flag_mismatch("out_link", result.out_link, w.out_link);
				if (result.out_dir !== w.out_dir)
					flag_mismatch("out_dir", result.out_dir, w.out_dir);
				if (result.out_volume !== w.out_volume)
					flag_mismatch("out_volume", result.out_volume, w.out_volume);
				if (result.out_capacity !== w.out_capacity)
					flag_mismatch("out_capacity", result.out_capacity, w.out_capacity);
			end
		end
	end

	task automatic track_beat(input tkvr_in_t c);
		bit [63:0]   cap, tod, ratio, vol_r, num, den, ln;
		tkvr_out_t   r;
		tkvr_entry_t e;
		if (c.mode == MODE_READ) begin
			r = '0;
			if (c.rank < DEPTH) begin
				e = rank_list[c.rank];
				r.valid_res    = (e.ratio != 0);
				r.ratio        = e.ratio;
				r.out_period   = e.period;
				r.out_link     = e.link;
				r.out_dir      = e.dir;
				r.out_volume   = e.volume;
				r.out_capacity = e.capacity;
			end
			pending_reads.push_back(r);
			return;
		end
		if (c.volume == 0)
			return;
		cap = (64'(c.capacity) * 64'(cap_scale) + 64'd128) >> 8;
		if (cap == 0)
			return;
		ln  = (c.lanes == 0) ? 64'd1 : 64'(c.lanes);
		tod = cap;
		if (c.use_found) begin
			tod = (cap * 64'(c.use_lanes) + ln / 2) / ln;
			if (tod == 0)
				tod = cap / 2;
		end
		if (tod == 0) begin
			ratio = 64'(RATIO_MAX);
		end else begin
			num   = 64'(c.volume) * 64'd100;
			den   = tod * 64'd16;
			ratio = (2 * num + den) / (2 * den);
			if (ratio > 64'(RATIO_MAX))
				ratio = 64'(RATIO_MAX);
		end
		vol_r = (64'(c.volume) + 64'd8) >> 4;
		if (vol_r > 64'(CAP_MAX))
			vol_r = 64'(CAP_MAX);
		if (tod > 64'(CAP_MAX))
			tod = 64'(CAP_MAX);
		e.ratio    = ratio[15:0];
		e.period   = c.period;
		e.link     = c.link;
		e.dir      = c.dir;
		e.volume   = vol_r[19:0];
		e.capacity = tod[19:0];
		// ties land behind equal ratios; the tail entry falls off
		for (int i = 0; i < DEPTH; i++) begin
			if (ratio > 64'(rank_list[i].ratio)) begin
				if (rank_list[i].ratio != 0 && i < DEPTH - 1)
					for (int j = DEPTH - 1; j > i; j--)
						rank_list[j] = rank_list[j - 1];
				rank_list[i] = e;
				break;
			end
		end
	endtask

	task automatic send_beat(input tkvr_in_t c, input bit typed = 1'b0,
			input tkvr_out_t want = '0);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
		track_beat(c);
		// a typed row replaces the expectation just queued for this read
		if (typed)
			pending_reads[pending_reads.size() - 1] = want;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// drain, let a trailing record finish, then write the scale
	task automatic set_capacity_scale(input bit [15:0] v);
		start <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_scale = v;
	endtask

	function automatic tkvr_in_t mk_rec(input bit [7:0] period, input bit [23:0] link,
			input bit dir, input bit [23:0] volume, input bit [19:0] capacity,
			input bit [3:0] lanes, input bit use_found, input bit [3:0] use_lanes);
		tkvr_in_t c;
		c           = '0;
		c.mode      = MODE_RECORD;
		c.period    = period;
		c.link      = link;
		c.dir       = dir;
		c.volume    = volume;
		c.capacity  = capacity;
		c.lanes     = lanes;
		c.use_found = use_found;
		c.use_lanes = use_lanes;
		return c;
	endfunction

	function automatic tkvr_in_t mk_read(input bit [6:0] rank);
		tkvr_in_t c;
		c      = '0;
		c.mode = MODE_READ;
		c.rank = rank;
		return c;
	endfunction

	task automatic add_row(input tkvr_in_t c, input bit typed, input tkvr_out_t want);
		stim_row_t r;
		r.c     = c;
		r.typed = typed;
		r.want  = want;
		dir_rows.push_back(r);
	endtask

	function automatic bit [31:0] rand_bits(input int hi);
		int w;
		w = $urandom_range(1, hi);
		return $urandom & ((32'd1 << w) - 1);
	endfunction

	function automatic tkvr_in_t rand_beat();
		tkvr_in_t c;
		c.mode      = MODE_RECORD;
		c.rank      = 7'($urandom);
		c.period    = 8'($urandom);
		c.link      = 24'($urandom);
		c.dir       = 1'($urandom);
		c.volume    = 24'(rand_bits(24));
		c.capacity  = 20'(rand_bits(20));
		c.lanes     = 4'($urandom);
		c.use_found = 1'($urandom);
		c.use_lanes = 4'($urandom);
		if ($urandom_range(0, 99) < 35) begin
			c.mode = MODE_READ;
			c.rank = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(DEPTH, 127))
				: 7'($urandom_range(0, DEPTH - 1));
		end else if ($urandom_range(0, 7) == 0) begin
			// same volume and capacity as the last record: forces a tie
			c.volume    = last_rec.volume;
			c.capacity  = last_rec.capacity;
			c.lanes     = last_rec.lanes;
			c.use_found = last_rec.use_found;
			c.use_lanes = last_rec.use_lanes;
		end else if ($urandom_range(0, 15) == 0) begin
			c.volume = $urandom_range(0, 1) ? 24'd0 : c.volume;
			c.capacity = $urandom_range(0, 1) ? 20'd0 : c.capacity;
		end
		return c;
	endfunction

	initial begin
		bit [15:0] scales [6];
		int        counts [6];
		tkvr_in_t  c;
		tkvr_out_t w;

		clk      = 1'b0;
		arst_n   = 1'b0;
		start    = 1'b0;
		cmd      = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		errors   = 0;
		gaps_on  = 1'b1;
		last_rec = '0;
		cap_scale = CFG_RESET;
		foreach (rank_list[i])
			rank_list[i] = '0;

		// empty list after reset, and ranks past the end
		add_row(mk_read(7'd0), 1'b1, '0);
		add_row(mk_read(7'd99), 1'b1, '0);
		add_row(mk_read(7'd100), 1'b1, '0);
		add_row(mk_read(7'd127), 1'b1, '0);
		// zero volume and zero capacity are dropped, then an ordinary record is kept
		add_row(mk_rec(8'd5, 24'd5, 1'b0, 24'd0, 20'd1000, 4'd1, 1'b0, 4'd0), 1'b0, '0);
		add_row(mk_rec(8'd6, 24'd6, 1'b0, 24'd800, 20'd0, 4'd1, 1'b0, 4'd0), 1'b0, '0);
		add_row(mk_rec(8'd7, 24'd7, 1'b0, 24'd800, 20'd1000, 4'd1, 1'b0, 4'd0), 1'b0, '0);
		// full volume over unit capacity: saturated ratio and volume
		add_row(mk_rec(8'hFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 20'd1, 4'hF, 1'b0, 4'd0),
			1'b0, '0);
		// lane-use result of zero on unit capacity: zero divisor, ties behind
		add_row(mk_rec(8'd1, 24'd2, 1'b0, 24'd16, 20'd1, 4'd1, 1'b1, 4'd0), 1'b0, '0);
		// tod past 20 bits
		add_row(mk_rec(8'd10, 24'd10, 1'b1, 24'hFFFFFF, 20'hFFFFF, 4'd1, 1'b1, 4'hF),
			1'b0, '0);
		// zero lanes counts as one
		add_row(mk_rec(8'd11, 24'd11, 1'b0, 24'h012345, 20'd3000, 4'd0, 1'b1, 4'd3),
			1'b0, '0);
		// ratio rounds to zero and is not stored
		add_row(mk_rec(8'd12, 24'd12, 1'b1, 24'd1, 20'hFFFFF, 4'd2, 1'b0, 4'd1), 1'b0, '0);
		w = '{valid_res: 1'b1, ratio: 16'hFFFF, out_period: 8'hFF, out_link: 24'hFFFFFF,
			out_dir: 1'b1, out_volume: 20'hFFFFF, out_capacity: 20'd1};
		add_row(mk_read(7'd0), 1'b1, w);
		w = '{valid_res: 1'b1, ratio: 16'hFFFF, out_period: 8'd1, out_link: 24'd2,
			out_dir: 1'b0, out_volume: 20'd1, out_capacity: 20'd0};
		add_row(mk_read(7'd1), 1'b1, w);
		for (int r = 2; r < 7; r++)
			add_row(mk_read(7'(r)), 1'b0, '0);
		add_row(mk_read(7'd99), 1'b0, '0);
		add_row(mk_read(7'd100), 1'b1, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

		scales = '{16'hFFFF, 16'd0, 16'($urandom), 16'd1, 16'($urandom), CFG_RESET};
		counts = '{360, 80, 360, 360, 360, 360};
		foreach (scales[p]) begin
			set_capacity_scale(scales[p]);
			for (int n = 0; n < counts[p]; n++) begin
				// stretches with and without idling; none in the last phase
				if (n % 40 == 0)
					gaps_on = (p != 5) && ($urandom_range(0, 2) != 0);
				c = rand_beat();
				if (c.mode == MODE_RECORD)
					last_rec = c;
				send_beat(c);
			end
		end

		start <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
